// ----- design/matrix4_multiply_top_defines.svh -----
// Assertion macros used by matrix4_multiply_top to check its own logic.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef MATRIX4_MULTIPLY_TOP_DEFINES_SVH
`define MATRIX4_MULTIPLY_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define MM4_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define MM4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/mm4_pkg.sv -----
package mm4_pkg;

    localparam int ELEM_W        = 32;
    localparam int PROD_W        = 2 * ELEM_W;
    localparam int ACC_W         = PROD_W + 2;
    localparam int FRACTION_BITS = 16;
    localparam int IDX_W         = 4;
    localparam int LOAD_W        = 5;
    localparam int STEP_W        = 6;

    localparam logic [IDX_W-1:0]  LAST_IDX  = 4'd15;
    localparam logic [LOAD_W-1:0] LAST_LOAD = 5'd31;
    localparam logic [STEP_W-1:0] LAST_STEP = 6'd63;
    localparam logic [1:0]        FIRST_K   = 2'd0;
    localparam logic [1:0]        LAST_K    = 2'd3;

    // Travels with one multiply-add through the pipeline.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;
    } mm4_tag_t;

endpackage

// ----- design/matrix4_multiply_top.sv -----
// Multiplies two 4x4 signed Q16.16 matrices held in column-major order. Raise
// start with one element on element_value for each request while busy is low:
// the sixteen elements of the first matrix, then the sixteen of the second.
// Loading takes one request per cycle while busy is low. The request that
// carries the 32nd element raises busy, and the block then works through
// the 64 multiply-adds one per cycle on a single shared multiplier, fed
// from two memories with registered reads. Results appear on product_value,
// product_index, last_of_run and saturated for exactly one cycle each, marked
// by result_valid, in index order 0 to 15; the receiver cannot stall them and
// must take each one in the cycle that it is shown. Busy falls with the
// sixteenth result. Each product element is the exact sum of four products,
// shifted right by the fraction width with rounding towards minus infinity
// and then clipped to 32 bits, with saturated marking a clipped value.
// Memory contents need no clearing after reset, since every entry is
// written before it is read.
`include "matrix4_multiply_top_defines.svh"

module matrix4_multiply_top
    import mm4_pkg::*;
#(
    parameter int FRAC_BITS = FRACTION_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [ELEM_W-1:0] element_value,
    output logic                     result_valid,
    output logic signed [ELEM_W-1:0] product_value,
    output logic [IDX_W-1:0]         product_index,
    output logic                     last_of_run,
    output logic                     saturated
);

    // Sequencer states: loading elements, issuing multiply-adds, draining the
    // pipeline until the sixteenth result has left.
    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [LOAD_W-1:0] load_count_reg, load_count_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              accept;

    mm4_tag_t                 issue_tag, done_tag;
    logic [IDX_W-1:0]         rd_addr_a, rd_addr_b;
    logic signed [ELEM_W-1:0] rd_data_a, rd_data_b;
    logic signed [ACC_W-1:0]  acc;

    logic signed [ACC_W-1:0]  shifted;
    logic                     overflow;
    logic signed [ELEM_W-1:0] clipped;

    logic                     result_valid_reg;
    logic signed [ELEM_W-1:0] product_value_reg;
    logic [IDX_W-1:0]         product_index_reg;
    logic                     last_of_run_reg;
    logic                     saturated_reg;

    assign busy   = (state_reg != ST_LOAD);
    assign accept = start && !busy;

    // The step counter walks j (column of the product), i (row) and k (the
    // inner index) with k innermost, so the four terms of each element follow
    // each other and the product index is simply the upper four bits.
    assign rd_addr_a = {step_reg[1:0], step_reg[3:2]};
    assign rd_addr_b = {step_reg[5:4], step_reg[1:0]};

    always_comb
    begin
        issue_tag.valid = (state_reg == ST_ISSUE);
        issue_tag.first = (step_reg[1:0] == FIRST_K);
        issue_tag.last  = (step_reg[1:0] == LAST_K);
        issue_tag.idx   = step_reg[5:2];
    end

    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        step_next       = step_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    load_count_next = load_count_reg + 5'd1;
                    if (load_count_reg == LAST_LOAD)
                    begin
                        state_next = ST_ISSUE;
                        step_next  = '0;
                    end
                end
            end
            ST_ISSUE:
            begin
                step_next = step_reg + 6'd1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (done_tag.valid && done_tag.idx == LAST_IDX)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            step_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            step_reg       <= step_next;
        end
    end

    mm4_mem u_mem
    (
        .clk       (clk),
        .wr_en     (accept),
        .wr_addr   (load_count_reg),
        .wr_data   (element_value),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    mm4_mac u_mac
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue_tag (issue_tag),
        .a_data    (rd_data_a),
        .b_data    (rd_data_b),
        .done_tag  (done_tag),
        .acc       (acc)
    );

    // An arithmetic shift of the exact sum gives the floor. The value fits in
    // 32 bits only when bit 31 and every bit above it agree.
    always_comb
    begin
        shifted  = acc >>> FRAC_BITS;
        overflow = !((&shifted[ACC_W-1:ELEM_W-1]) || !(|shifted[ACC_W-1:ELEM_W-1]));
        if (overflow)
        begin
            clipped = shifted[ACC_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}}
                                       : {1'b0, {(ELEM_W-1){1'b1}}};
        end
        else
        begin
            clipped = shifted[ELEM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= done_tag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_tag.valid)
        begin
            product_value_reg <= clipped;
            product_index_reg <= done_tag.idx;
            last_of_run_reg   <= (done_tag.idx == LAST_IDX);
            saturated_reg     <= overflow;
        end
    end

    assign result_valid  = result_valid_reg;
    assign product_value = product_value_reg;
    assign product_index = product_index_reg;
    assign last_of_run   = last_of_run_reg;
    assign saturated     = saturated_reg;

    // The sixteenth result ends the run, so the block is free again with it.
    `MM4_ASSERT_NOW(a_last_frees, result_valid && last_of_run, !busy,
                    "busy still high with the last result of a run")
    // Every other result comes out while the run still holds the block.
    `MM4_ASSERT_NOW(a_result_in_run, result_valid && !last_of_run, busy,
                    "result shown outside a run")
    // The request with the 32nd element starts the computation.
    `MM4_ASSERT_NEXT(a_run_starts, accept && load_count_reg == LAST_LOAD,
                     busy && load_count_reg == '0,
                     "final element did not start a run")
    // A clipped value is always one of the two limits.
    `MM4_ASSERT_NOW(a_sat_limits, result_valid && saturated,
                    product_value == 32'sh7FFFFFFF || product_value == 32'sh80000000,
                    "saturated value is not a limit")

endmodule

// ----- design/mm4_mem.sv -----
module mm4_mem
    import mm4_pkg::*;
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [LOAD_W-1:0]        wr_addr,
    input  logic signed [ELEM_W-1:0] wr_data,
    input  logic [IDX_W-1:0]         rd_addr_a,
    input  logic [IDX_W-1:0]         rd_addr_b,
    output logic signed [ELEM_W-1:0] rd_data_a,
    output logic signed [ELEM_W-1:0] rd_data_b
);

    // The upper address bit selects the second matrix.
    logic signed [ELEM_W-1:0] mem_a [16];
    logic signed [ELEM_W-1:0] mem_b [16];

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_addr[LOAD_W-1])
        begin
            mem_a[wr_addr[IDX_W-1:0]] <= wr_data;
        end
        rd_data_a <= mem_a[rd_addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_addr[LOAD_W-1])
        begin
            mem_b[wr_addr[IDX_W-1:0]] <= wr_data;
        end
        rd_data_b <= mem_b[rd_addr_b];
    end

endmodule

// ----- design/mm4_mac.sv -----
module mm4_mac
    import mm4_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mm4_tag_t                 issue_tag,
    input  logic signed [ELEM_W-1:0] a_data,
    input  logic signed [ELEM_W-1:0] b_data,
    output mm4_tag_t                 done_tag,
    output logic signed [ACC_W-1:0]  acc
);

    mm4_tag_t                 tag1_reg, tag2_reg, done_reg, done_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    // The exact 66-bit sum; the first term of each element restarts it.
    always_comb
    begin
        acc_next = (tag2_reg.first ? '0 : acc_reg)
                 + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    end

    // Only the fourth term of an element marks a finished sum.
    always_comb
    begin
        done_next       = tag2_reg;
        done_next.valid = tag2_reg.valid && tag2_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            done_reg <= '0;
        end
        else
        begin
            tag1_reg <= issue_tag;
            tag2_reg <= tag1_reg;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_data * b_data;
        if (tag2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done_tag = done_reg;
    assign acc      = acc_reg;

endmodule
